// ===== hdl/dv128_pkg.sv =====
// ----------------------------------------------------------------------------
// dv128_pkg: shared types and constants for the 128 by 64 bit divider
// Transaction structs for both directions, word width and sequencer states.
// ----------------------------------------------------------------------------
package dv128_pkg;

    localparam int WORD_BITS  = 64;
    localparam int STEP_COUNT = 2 * WORD_BITS;
    localparam int COUNT_BITS = $clog2(STEP_COUNT);

    typedef struct packed {
        logic [WORD_BITS-1:0] dividend_high;
        logic [WORD_BITS-1:0] dividend_low;
        logic [WORD_BITS-1:0] divisor_value;
    } in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] quotient_high;
        logic [WORD_BITS-1:0] quotient_low;
        logic [WORD_BITS-1:0] remainder_value;
        logic                 divide_error;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== hdl/divide_128_by_64.sv =====
// ----------------------------------------------------------------------------
// divide_128_by_64: unsigned 128-bit by 64-bit integer divider
// Radix-2 restoring division with one shared 65-bit subtractor.
//
// Usage:
//   - drive operands and raise start; the transaction is taken at a rising
//     edge where start is high and busy is low
//   - busy stays high from the next cycle until the result has been shown
//   - done marks the result on result for exactly one cycle; the
//     receiver cannot hold it off and must take it in that cycle
//   - a nonzero divisor takes 128 subtract steps, one quotient bit per cycle:
//     done rises after the last step, busy drops in the cycle after the
//     done cycle, and the next transaction can be taken at the edge that
//     ends that cycle
//   - a zero divisor skips the loop: done rises the cycle after acceptance
//     with divide_error set, the dividend echoed and a zero remainder
//   - the step rate is set by the single subtract-and-compare unit
//   - reset (rst_n low, asynchronous) returns the sequencer to idle and
//     drops busy and done; no result in flight survives it
// ----------------------------------------------------------------------------
module divide_128_by_64
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dv128_pkg::in_t   operands,
    output logic             done,
    output dv128_pkg::out_t  result
);

    localparam int W = dv128_pkg::WORD_BITS;

    dv128_pkg::state_t                state_reg, state_next;
    logic [dv128_pkg::COUNT_BITS-1:0] count_reg, count_next;

    // dividend bits shift out at the top while quotient bits enter at the bottom
    logic [2*W-1:0] dq_reg, dq_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   divisor_reg, divisor_next;
    logic           error_reg, error_next;

    logic [W+1:0]   trial;
    logic           take;
    logic           accept;

    assign accept = start && !busy;

    // 65-bit partial remainder minus divisor, extra top bit is the borrow
    assign trial = {1'b0, rem_reg, dq_reg[2*W-1]} - {2'b00, divisor_reg};
    assign take  = !trial[W+1];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        error_next   = error_reg;
        unique case (state_reg)
            dv128_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    dq_next      = {operands.dividend_high, operands.dividend_low};
                    rem_next     = '0;
                    divisor_next = operands.divisor_value;
                    count_next   = '0;
                    if (operands.divisor_value == '0)
                    begin
                        error_next = 1'b1;
                        state_next = dv128_pkg::ST_DONE;
                    end
                    else
                    begin
                        error_next = 1'b0;
                        state_next = dv128_pkg::ST_RUN;
                    end
                end
            end
            dv128_pkg::ST_RUN:
            begin
                rem_next   = take ? trial[W-1:0] : {rem_reg[W-2:0], dq_reg[2*W-1]};
                dq_next    = {dq_reg[2*W-2:0], take};
                count_next = count_reg + 1'b1;
                if (count_reg == dv128_pkg::COUNT_BITS'(dv128_pkg::STEP_COUNT - 1))
                begin
                    state_next = dv128_pkg::ST_DONE;
                end
            end
            dv128_pkg::ST_DONE:
            begin
                state_next = dv128_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dv128_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dv128_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        error_reg   <= error_next;
    end

    assign busy = (state_reg != dv128_pkg::ST_IDLE);
    assign done = (state_reg == dv128_pkg::ST_DONE);

    assign result.quotient_high   = dq_reg[2*W-1:W];
    assign result.quotient_low    = dq_reg[W-1:0];
    assign result.remainder_value = rem_reg;
    assign result.divide_error    = error_reg;

    // done is a single-cycle strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // zero divisor bypasses the loop
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operands.divisor_value == '0) |=> done && result.divide_error)
        else $error("zero divisor did not report an error next cycle");

    // nonzero divisor starts the loop from step zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operands.divisor_value != '0)
            |=> (state_reg == dv128_pkg::ST_RUN) && (count_reg == '0) && (rem_reg == '0))
        else $error("loop did not start cleanly");

    // the step counter only moves inside the loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (state_reg == dv128_pkg::ST_RUN))
        else $error("step counter nonzero outside the loop");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dv128_pkg::ST_RUN) |-> (rem_reg < divisor_reg))
        else $error("partial remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.divide_error |-> (result.remainder_value < divisor_reg))
        else $error("final remainder not below divisor");

endmodule
